/* rtl/vn_pkg.sv */
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants
// Widths and the stage record that travels along the normalize cell chain.
// ----------------------------------------------------------------------------
package vn_pkg;

	// Component and result widths.
	localparam int unsigned COMP_W  = 32;
	localparam int unsigned OUT_W   = 32;
	localparam int unsigned FRAC    = 30;
	localparam int unsigned QUOT_W  = FRAC + 1;
	// Sum of four squares of up to 32-bit magnitudes.
	localparam int unsigned SUM_W   = 66;
	// Remainder and partial-product width for the digit recurrence.
	localparam int unsigned ACC_W   = 128;
	localparam int unsigned LANES   = 4;

	// One component as it moves through the cells.
	typedef struct packed {
		logic              neg;
		logic [ACC_W-1:0]  rem;
		logic [ACC_W-1:0]  prod;
		logic [QUOT_W-1:0] quot;
	} lane_t;

	// One vector in flight.
	typedef struct packed {
		logic                   valid;
		logic                   zero;
		logic [SUM_W-1:0]       sum;
		lane_t [LANES-1:0]      lane;
	} vec_t;

endpackage

/* rtl/vn_front.sv */
// ----------------------------------------------------------------------------
// vn_front: magnitude, square and sum stages
// Splits each component into sign and magnitude, squares it, sums the
// squares and seeds the remainder for the quotient cells.
// ----------------------------------------------------------------------------
module vn_front #(
	parameter int unsigned COMPONENT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_beat,
	input  logic [vn_pkg::COMP_W-1:0]     comp [vn_pkg::LANES],
	output vn_pkg::vec_t                  vec
);

	localparam int unsigned CW = COMPONENT_WIDTH;

	logic                 valid_s1, valid_s2;
	logic [CW-1:0]        mag_s1  [vn_pkg::LANES];
	logic                 neg_s1  [vn_pkg::LANES];
	logic [2*CW-1:0]      sq_s2   [vn_pkg::LANES];
	logic                 neg_s2  [vn_pkg::LANES];
	logic [vn_pkg::SUM_W-1:0] sum_c;
	vn_pkg::vec_t         vec_s3;

	// Valid bits of the first two front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_beat;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: sign and magnitude of the low bits of each component.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < vn_pkg::LANES; i++) begin
				neg_s1[i] <= comp[i][CW-1];
				mag_s1[i] <= comp[i][CW-1] ? (~comp[i][CW-1:0] + CW'(1)) : comp[i][CW-1:0];
			end
		end
	end

	// Stage 2: one square per lane.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < vn_pkg::LANES; i++) begin
				sq_s2[i]  <= mag_s1[i] * mag_s1[i];
				neg_s2[i] <= neg_s1[i];
			end
		end
	end

	// Sum of the four squares.
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < vn_pkg::LANES; i++) begin
			sum_c = sum_c + vn_pkg::SUM_W'(sq_s2[i]);
		end
	end

	// Stage 3: seed remainder with m^2 * 2^60, empty quotient.
	// Only the valid bit is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_s3.valid <= 1'b0;
		end else if (en) begin
			vec_s3.valid <= valid_s2;
			vec_s3.zero  <= (sum_c == '0);
			vec_s3.sum   <= sum_c;
			for (int i = 0; i < vn_pkg::LANES; i++) begin
				vec_s3.lane[i].neg  <= neg_s2[i];
				vec_s3.lane[i].rem  <= vn_pkg::ACC_W'(sq_s2[i]) << (2 * vn_pkg::FRAC);
				vec_s3.lane[i].prod <= '0;
				vec_s3.lane[i].quot <= '0;
			end
		end
	end

	assign vec = vec_s3;

endmodule

/* rtl/vn_cell.sv */
// ----------------------------------------------------------------------------
// vn_cell: one quotient digit
// Settles bit BIT of every lane's quotient q, the largest value with
// q*q*S <= m*m*2^60, keeping the remainder and S*q up to date.
// ----------------------------------------------------------------------------
module vn_cell #(
	parameter int unsigned BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  vn_pkg::vec_t  vec_in,
	output vn_pkg::vec_t  vec_out
);

	vn_pkg::vec_t vec_q;
	vn_pkg::vec_t vec_c;
	logic [vn_pkg::ACC_W-1:0] sum_w;
	logic [vn_pkg::ACC_W-1:0] step;

	assign sum_w = vn_pkg::ACC_W'(vec_in.sum);

	// Trial: (q + 2^b)^2 * S - q^2 * S = S*q*2^(b+1) + S*2^(2b).
	always_comb begin
		vec_c = vec_in;
		step  = '0;
		for (int i = 0; i < vn_pkg::LANES; i++) begin
			step = (vec_in.lane[i].prod << (BIT + 1)) + (sum_w << (2 * BIT));
			if (vec_in.lane[i].rem >= step) begin
				vec_c.lane[i].rem       = vec_in.lane[i].rem - step;
				vec_c.lane[i].prod      = vec_in.lane[i].prod + (sum_w << BIT);
				vec_c.lane[i].quot[BIT] = 1'b1;
			end
		end
	end

	// Register of this cell; only the valid bit is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_q.valid <= 1'b0;
		end else if (en) begin
			vec_q <= vec_c;
		end
	end

	assign vec_out = vec_q;

endmodule

/* rtl/vector4_normalise.sv */
// ----------------------------------------------------------------------------
// vector4_normalise: four-component vector normalize
// The pipeline is three front stages, 31 quotient cells and one output register.
// Throughput is one vector per cycle; the chain advances as one pipeline.
// The chain stalls only while the output beat waits for out_ready.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module vector4_normalise #(
	parameter int unsigned COMPONENT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] comp_x,
	input  logic [31:0] comp_y,
	input  logic [31:0] comp_z,
	input  logic [31:0] comp_w,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] unit_x,
	output logic [31:0] unit_y,
	output logic [31:0] unit_z,
	output logic [31:0] unit_w,
	output logic        zero_vector
);

	localparam int unsigned NCELL = vn_pkg::QUOT_W;

	logic                       en;
	logic [vn_pkg::COMP_W-1:0]  comp [vn_pkg::LANES];
	vn_pkg::vec_t               chain [NCELL+1];
	logic                       valid_q;
	logic                       zero_q;
	logic [vn_pkg::OUT_W-1:0]   unit_q [vn_pkg::LANES];
	vn_pkg::vec_t               last;

	// Whole chain moves whenever the output register can take a beat.
	assign en       = !valid_q || out_ready;
	assign in_ready = en;

	assign comp[0] = comp_x;
	assign comp[1] = comp_y;
	assign comp[2] = comp_z;
	assign comp[3] = comp_w;

	vn_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_beat (in_valid),
		.comp    (comp),
		.vec     (chain[0])
	);

	// Cells from the top quotient bit down to bit zero.
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		vn_cell #(.BIT(NCELL - 1 - k)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vec_in  (chain[k]),
			.vec_out (chain[k+1])
		);
	end

	assign last = chain[NCELL];

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= last.valid;
		end
	end

	// Apply signs; a zero vector forces zero components.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= last.zero;
			for (int i = 0; i < vn_pkg::LANES; i++) begin
				if (last.zero) begin
					unit_q[i] <= '0;
				end else if (last.lane[i].neg) begin
					unit_q[i] <= vn_pkg::OUT_W'(0) - vn_pkg::OUT_W'(last.lane[i].quot);
				end else begin
					unit_q[i] <= vn_pkg::OUT_W'(last.lane[i].quot);
				end
			end
		end
	end

	assign out_valid   = valid_q;
	assign zero_vector = zero_q;
	assign unit_x      = unit_q[0];
	assign unit_y      = unit_q[1];
	assign unit_z      = unit_q[2];
	assign unit_w      = unit_q[3];

endmodule

/* rtl/vn_checker.sv */
// ----------------------------------------------------------------------------
// vn_checker: port-level checks for the normalize block
// Watches the top-level ports and flags output beats out of range, zero beats with nonzero parts, and stalls.
// ----------------------------------------------------------------------------
module vn_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_ready,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] unit_x,
	input  logic [31:0] unit_y,
	input  logic [31:0] unit_z,
	input  logic [31:0] unit_w,
	input  logic        zero_vector
);

	// A zero vector beat carries zero components.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_vector) |->
		(unit_x == 32'd0 && unit_y == 32'd0 && unit_z == 32'd0 && unit_w == 32'd0))
		else $error("zero vector beat with nonzero component");

	// Components x and w stay within plus or minus one in Q1.30.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		(($signed(unit_x) <= 32'sd1073741824 && $signed(unit_x) >= -32'sd1073741824) &&
		 ($signed(unit_w) <= 32'sd1073741824 && $signed(unit_w) >= -32'sd1073741824)))
		else $error("unit component out of range");

	// An empty output register never blocks the input.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// A stalled output beat stays valid and holds unit_x and zero_vector.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(unit_x) && $stable(zero_vector)))
		else $error("stalled output beat changed");

endmodule

bind vector4_normalise vn_checker u_vn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.unit_x      (unit_x),
	.unit_y      (unit_y),
	.unit_z      (unit_z),
	.unit_w      (unit_w),
	.zero_vector (zero_vector)
);
